FILE: hdl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types and constants of the heart-rate packet parser: result codes,
// flag bit positions, sequencer states and the divider request/response.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int RATE_W    = 8;
    localparam int CNT_W     = 16;
    localparam int TOT_W     = 24;
    localparam int ENERGY_W  = 16;
    localparam int RR_W      = 7;
    localparam int POS_W     = 8;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] WINDOW_LENGTH_RESET = 16'd28800;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FORMAT = 2'd1;
    localparam logic [1:0] STATUS_SHORT  = 2'd2;

    // flag byte bit positions
    localparam int FLAG_FORMAT  = 0;
    localparam int FLAG_CONTACT = 1;
    localparam int FLAG_SUPPORT = 2;
    localparam int FLAG_ENERGY  = 3;
    localparam int FLAG_RR      = 4;

    localparam logic [POS_W-1:0] POS_MAX         = 8'd255;
    localparam logic [POS_W-1:0] FIXED_PLAIN     = 8'd2;
    localparam logic [POS_W-1:0] FIXED_ENERGY    = 8'd4;
    localparam logic [RATE_W-1:0] RATE_MIN_RESET = 8'd255;
    localparam logic [RATE_W-1:0] RATE_MAX_RESET = 8'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [TOT_W-1:0]   dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [RATE_W-1:0]  quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [RATE_W-1:0]   heart_rate;
        logic                contact_detected;
        logic                contact_supported;
        logic                energy_present;
        logic [ENERGY_W-1:0] energy_value;
        logic                rr_present;
        logic [RR_W-1:0]     rr_count;
        logic [RATE_W-1:0]   min_rate;
        logic [RATE_W-1:0]   max_rate;
        logic [RATE_W-1:0]   avg_rate;
        logic [CNT_W-1:0]    sample_count;
    } res_t;

endpackage

FILE: hdl/hrp_if.sv
// ----------------------------------------------------------------------------
// hrp_if
// Valid/ready channels of the heart-rate packet parser: byte requests in,
// packet results out, and the window length configuration write.
// ----------------------------------------------------------------------------
interface hrp_pkt_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, command, data_byte, last_byte, input ready);
    modport sink   (input valid, command, data_byte, last_byte, output ready);
endinterface

interface hrp_res_if
    import hrp_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [RATE_W-1:0]   heart_rate;
    logic                contact_detected;
    logic                contact_supported;
    logic                energy_present;
    logic [ENERGY_W-1:0] energy_value;
    logic                rr_present;
    logic [RR_W-1:0]     rr_count;
    logic [RATE_W-1:0]   min_rate;
    logic [RATE_W-1:0]   max_rate;
    logic [RATE_W-1:0]   avg_rate;
    logic [CNT_W-1:0]    sample_count;

    modport source (
        output valid, status, heart_rate, contact_detected, contact_supported,
               energy_present, energy_value, rr_present, rr_count, min_rate,
               max_rate, avg_rate, sample_count,
        input  ready
    );
    modport sink (
        input  valid, status, heart_rate, contact_detected, contact_supported,
               energy_present, energy_value, rr_present, rr_count, min_rate,
               max_rate, avg_rate, sample_count,
        output ready
    );
endinterface

interface hrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] window_length;

    modport source (output valid, window_length, input ready);
    modport sink   (input valid, window_length, output ready);
endinterface

FILE: hdl/hrp_ram.sv
// ----------------------------------------------------------------------------
// hrp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module hrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/hrp_div.sv
// ----------------------------------------------------------------------------
// hrp_div
// Iterative restoring divider for the window average: one compare and
// subtract per cycle, eight quotient bits, quotient known to fit in 8 bits.
// ----------------------------------------------------------------------------
module hrp_div
    import hrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [TOT_W-1:0]  rem_reg,   rem_next;
    logic [TOT_W-1:0]  dsh_reg,   dsh_next;
    logic [RATE_W-1:0] quot_reg,  quot_next;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            // align the divisor with the top quotient bit
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = req.dividend;
            dsh_next  = TOT_W'(req.divisor) << (DIV_STEPS - 1);
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[RATE_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

FILE: hdl/heart_rate_packet_parser_stats.sv
// ----------------------------------------------------------------------------
// heart_rate_packet_parser_stats
// Parses heart-rate measurement notifications byte by byte and reports the
// decoded packet with min, max and sliding-window average statistics.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------------
//  pkt     | in  | valid / ready | command, data_byte, last_byte
//  res     | out | valid / ready | status, flags, rate, energy, rr, stats
//  cfg     | in  | valid / ready | window_length (always ready)
//
//  A data byte or a clear request leaves ready high; after a final byte ready
//  stays low through evaluation and result issue when rejected or short, and
//  through RAM read, update, the 8-step divider and result issue when accepted.
//  Reset clears the statistics and latches the window length; the window RAM
//  needs no clearing, since only entries written since the last clear are read.
//  A stalled result holds in the output register; the next result waits behind it.
//
module heart_rate_packet_parser_stats
    import hrp_pkg::*;
#(
    parameter int WINDOW_DEPTH = 32768
) (
    input  logic      clk,
    input  logic      rst_n,
    hrp_pkt_if.sink   pkt,
    hrp_res_if.source res,
    hrp_cfg_if.sink   cfg
);

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W  = CNT_W + 1;
    localparam logic [LEN_W-1:0] DEPTH_WIDE  = LEN_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_SHORT = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] LEN_RESET   =
        (int'(WINDOW_LENGTH_RESET) > WINDOW_DEPTH) ? DEPTH_SHORT : WINDOW_LENGTH_RESET;

    // sequencer
    state_t state_reg, state_next;

    // packet capture
    logic [POS_W-1:0]    pos_reg,      pos_next;
    logic [POS_W-1:0]    len_reg,      len_next;
    logic [7:0]          flags_reg,    flags_next;
    logic [RATE_W-1:0]   rate_reg,     rate_next;
    logic [7:0]          elo_reg,      elo_next;
    logic [7:0]          ehi_reg,      ehi_next;

    // decoded packet, held until the result issues
    logic [1:0]          pend_status_reg, pend_status_next;
    logic [RATE_W-1:0]   pend_rate_reg,   pend_rate_next;
    logic [ENERGY_W-1:0] pend_energy_reg, pend_energy_next;
    logic [RR_W-1:0]     pend_rr_reg,     pend_rr_next;

    // statistics
    logic [CNT_W-1:0]    wlen_cfg_reg;
    logic [CNT_W-1:0]    win_len_reg,  win_len_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    logic [TOT_W-1:0]    total_reg,    total_next;
    logic [ADDR_W-1:0]   wr_ptr_reg,   wr_ptr_next;
    logic [RATE_W-1:0]   min_reg,      min_next;
    logic [RATE_W-1:0]   max_reg,      max_next;
    logic [RATE_W-1:0]   avg_reg,      avg_next;

    // output register
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg,       res_next;

    // control
    logic                pkt_ready;
    logic                pkt_fire;
    logic                res_free;
    logic                res_load;
    logic                ram_rd_en;
    logic                ram_wr_en;
    logic [RATE_W-1:0]   ram_rd_data;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // evaluation of a finished packet
    logic                e_flag;
    logic                r_flag;
    logic [POS_W-1:0]    fixed_len;
    logic [POS_W-1:0]    rr_bytes;
    logic [1:0]          eval_status;
    logic [CNT_W-1:0]    len_clamped;
    logic [POS_W-1:0]    pos_inc;

    // window update
    logic                win_full;
    logic [TOT_W-1:0]    upd_total;
    logic [CNT_W-1:0]    upd_count;
    logic [LEN_W-1:0]    wr_ptr_inc;

    assign pkt_fire = pkt.valid && pkt_ready;
    assign res_free = !res_valid_reg || res.ready;

    assign e_flag    = flags_reg[FLAG_ENERGY];
    assign r_flag    = flags_reg[FLAG_RR];
    assign fixed_len = e_flag ? FIXED_ENERGY : FIXED_PLAIN;
    assign rr_bytes  = len_reg - fixed_len;
    assign pos_inc   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;

    // format check wins over the length check
    always_comb
    begin
        if (flags_reg[FLAG_FORMAT])
        begin
            eval_status = STATUS_FORMAT;
        end
        else if (len_reg < fixed_len)
        begin
            eval_status = STATUS_SHORT;
        end
        else
        begin
            eval_status = STATUS_OK;
        end
    end

    // zero means one, anything beyond the RAM means the whole RAM
    always_comb
    begin
        if (wlen_cfg_reg == '0)
        begin
            len_clamped = CNT_W'(1);
        end
        else if (LEN_W'(wlen_cfg_reg) > DEPTH_WIDE)
        begin
            len_clamped = DEPTH_SHORT;
        end
        else
        begin
            len_clamped = wlen_cfg_reg;
        end
    end

    // once full, drop the oldest rate before adding the new one
    assign win_full   = (count_reg == win_len_reg);
    assign upd_total  = total_reg - (win_full ? TOT_W'(ram_rd_data) : '0)
                      + TOT_W'(pend_rate_reg);
    assign upd_count  = win_full ? count_reg : count_reg + 1'b1;
    assign wr_ptr_inc = LEN_W'(wr_ptr_reg) + 1'b1;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_fire && !pkt.command && pkt.last_byte)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = (eval_status == STATUS_OK) ? ST_UPDATE : ST_RESULT;
            end
            ST_UPDATE:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    always_comb
    begin
        pkt_ready = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   pkt_ready = 1'b1;
            ST_EVAL:   ram_rd_en = 1'b1;
            ST_UPDATE: ram_wr_en = 1'b1;
            ST_DIVIDE: ;
            ST_RESULT: res_load  = res_free;
            default:   ;
        endcase
    end

    // start the divider on the updated window totals
    assign div_req.start    = ram_wr_en;
    assign div_req.dividend = upd_total;
    assign div_req.divisor  = upd_count;

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        pos_next         = pos_reg;
        len_next         = len_reg;
        flags_next       = flags_reg;
        rate_next        = rate_reg;
        elo_next         = elo_reg;
        ehi_next         = ehi_reg;
        pend_status_next = pend_status_reg;
        pend_rate_next   = pend_rate_reg;
        pend_energy_next = pend_energy_reg;
        pend_rr_next     = pend_rr_reg;
        win_len_next     = win_len_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        wr_ptr_next      = wr_ptr_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        avg_next         = avg_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_fire && pkt.command)
                begin
                    // clear request: reset statistics, drop any partial packet
                    win_len_next = len_clamped;
                    count_next   = '0;
                    total_next   = '0;
                    wr_ptr_next  = '0;
                    min_next     = RATE_MIN_RESET;
                    max_next     = RATE_MAX_RESET;
                    avg_next     = '0;
                    pos_next     = '0;
                end
                else if (pkt_fire)
                begin
                    case (pos_reg)
                        8'd0:    flags_next = pkt.data_byte;
                        8'd1:    rate_next  = pkt.data_byte;
                        8'd2:    elo_next   = pkt.data_byte;
                        8'd3:    ehi_next   = pkt.data_byte;
                        default: ;
                    endcase
                    pos_next = pos_inc;
                    if (pkt.last_byte)
                    begin
                        len_next = pos_inc;
                        pos_next = '0;
                    end
                end
            end
            ST_EVAL:
            begin
                pend_status_next = eval_status;
                pend_rate_next   = '0;
                pend_energy_next = '0;
                pend_rr_next     = '0;
                if (eval_status == STATUS_OK)
                begin
                    pend_rate_next = rate_reg;
                    if (e_flag)
                    begin
                        pend_energy_next = {ehi_reg, elo_reg};
                    end
                    if (r_flag)
                    begin
                        pend_rr_next = rr_bytes[POS_W-1:1];
                    end
                    if (rate_reg < min_reg)
                    begin
                        min_next = rate_reg;
                    end
                    if (rate_reg > max_reg)
                    begin
                        max_next = rate_reg;
                    end
                end
            end
            ST_UPDATE:
            begin
                total_next = upd_total;
                count_next = upd_count;
                if (wr_ptr_inc >= LEN_W'(win_len_reg))
                begin
                    wr_ptr_next = '0;
                end
                else
                begin
                    wr_ptr_next = wr_ptr_inc[ADDR_W-1:0];
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    avg_next = div_rsp.quotient;
                end
            end
            ST_RESULT: ;
            default:   ;
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next             = 1'b1;
            res_next.status            = pend_status_reg;
            res_next.heart_rate        = pend_rate_reg;
            res_next.contact_detected  = flags_reg[FLAG_CONTACT];
            res_next.contact_supported = flags_reg[FLAG_SUPPORT];
            res_next.energy_present    = e_flag;
            res_next.energy_value      = pend_energy_reg;
            res_next.rr_present        = r_flag;
            res_next.rr_count          = pend_rr_reg;
            res_next.min_rate          = min_reg;
            res_next.max_rate          = max_reg;
            res_next.avg_rate          = avg_reg;
            res_next.sample_count      = count_reg;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            len_reg       <= '0;
            flags_reg     <= '0;
            rate_reg      <= '0;
            elo_reg       <= '0;
            ehi_reg       <= '0;
            wlen_cfg_reg  <= WINDOW_LENGTH_RESET;
            win_len_reg   <= LEN_RESET;
            count_reg     <= '0;
            total_reg     <= '0;
            wr_ptr_reg    <= '0;
            min_reg       <= RATE_MIN_RESET;
            max_reg       <= RATE_MAX_RESET;
            avg_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            flags_reg     <= flags_next;
            rate_reg      <= rate_next;
            elo_reg       <= elo_next;
            ehi_reg       <= ehi_next;
            win_len_reg   <= win_len_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            wr_ptr_reg    <= wr_ptr_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            avg_reg       <= avg_next;
            res_valid_reg <= res_valid_next;
            // latch a new window length; it takes effect at the next clear
            if (cfg.valid)
            begin
                wlen_cfg_reg <= cfg.window_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_rate_reg   <= pend_rate_next;
        pend_energy_reg <= pend_energy_next;
        pend_rr_reg     <= pend_rr_next;
        res_reg         <= res_next;
    end

    // ---------------------------------------------------------------- window RAM
    hrp_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (pend_rate_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (wr_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------- average divider
    hrp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------- ports
    assign pkt.ready = pkt_ready;
    assign cfg.ready = 1'b1;

    assign res.valid             = res_valid_reg;
    assign res.status            = res_reg.status;
    assign res.heart_rate        = res_reg.heart_rate;
    assign res.contact_detected  = res_reg.contact_detected;
    assign res.contact_supported = res_reg.contact_supported;
    assign res.energy_present    = res_reg.energy_present;
    assign res.energy_value      = res_reg.energy_value;
    assign res.rr_present        = res_reg.rr_present;
    assign res.rr_count          = res_reg.rr_count;
    assign res.min_rate          = res_reg.min_rate;
    assign res.max_rate          = res_reg.max_rate;
    assign res.avg_rate          = res_reg.avg_rate;
    assign res.sample_count      = res_reg.sample_count;

endmodule

FILE: hdl/hrp_checker.sv
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks of the heart-rate packet parser, bound to the top level.
// ----------------------------------------------------------------------------
module hrp_checker
    import hrp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                pkt_valid,
    input logic                pkt_ready,
    input logic                pkt_command,
    input logic                pkt_last_byte,
    input logic                res_valid,
    input logic                res_ready,
    input logic [1:0]          res_status,
    input logic [RATE_W-1:0]   res_heart_rate,
    input logic [ENERGY_W-1:0] res_energy_value,
    input logic [RR_W-1:0]     res_rr_count,
    input logic [RATE_W-1:0]   res_min_rate,
    input logic [RATE_W-1:0]   res_max_rate,
    input logic [RATE_W-1:0]   res_avg_rate,
    input logic [CNT_W-1:0]    res_sample_count
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status)
            && $stable(res_heart_rate) && $stable(res_avg_rate))
    else $error("stalled result changed");

    // drop decoded payload of rejected or short packets
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != STATUS_OK |->
            res_heart_rate == '0 && res_energy_value == '0 && res_rr_count == '0)
    else $error("rejected packet carries payload");

    // keep the average between the extremes of a non-empty window
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_sample_count != '0 |->
            res_min_rate <= res_avg_rate && res_avg_rate <= res_max_rate)
    else $error("average outside min/max");

    // block new requests while a finished packet is evaluated
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready && !pkt_command && pkt_last_byte |=> !pkt_ready)
    else $error("ready right after final byte");

endmodule

bind heart_rate_packet_parser_stats hrp_checker u_hrp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pkt_valid        (pkt.valid),
    .pkt_ready        (pkt.ready),
    .pkt_command      (pkt.command),
    .pkt_last_byte    (pkt.last_byte),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_status       (res.status),
    .res_heart_rate   (res.heart_rate),
    .res_energy_value (res.energy_value),
    .res_rr_count     (res.rr_count),
    .res_min_rate     (res.min_rate),
    .res_max_rate     (res.max_rate),
    .res_avg_rate     (res.avg_rate),
    .res_sample_count (res.sample_count)
);
